FILE: hw/rtl/dihedral_subset_rotation_top_defines.svh
// assertion macros for the dihedral subset rotation block
`ifndef DIHEDRAL_SUBSET_ROTATION_TOP_DEFINES_SVH
`define DIHEDRAL_SUBSET_ROTATION_TOP_DEFINES_SVH

// same-cycle implication, checked on clk_i outside reset
`define DSR_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dsr assertion failed");

// next-cycle implication, checked on clk_i outside reset
`define DSR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dsr assertion failed");

`endif

FILE: hw/rtl/dsr_pkg.sv
// shared widths, register codes and stage control type for the rotation pipeline
package dsr_pkg;

  localparam int NODE_BITS  = 12;
  localparam int COORD_W    = 24;
  localparam int COEF_FRAC  = 16;
  localparam int COEF_W     = COEF_FRAC + 2;
  localparam int COEFS_W    = 3 * COEF_W;
  localparam int PROD_W     = COORD_W + COEF_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEFS_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_X_COEFS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_COEFS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Z_COEFS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_MODE = 3'd4;

  // side mode codes
  localparam logic SIDE_PHI = 1'b0;
  localparam logic SIDE_PSI = 1'b1;

  // identity matrix at reset, one weight of 1.0 per output
  localparam logic [COEFS_W-1:0] X_COEFS_RST = COEFS_W'(1) << COEF_FRAC;
  localparam logic [COEFS_W-1:0] Y_COEFS_RST = COEFS_W'(1) << (COEF_FRAC + COEF_W);
  localparam logic [COEFS_W-1:0] Z_COEFS_RST = COEFS_W'(1) << (COEF_FRAC + 2 * COEF_W);

  // half an output lsb, for round to nearest with ties up
  localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) << (COEF_FRAC - 1);

  // saturation bounds in the wide domain
  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(-(64'sd1 <<< (COORD_W - 1)));

  // load enables for the arithmetic stages
  typedef struct packed {
    logic en_s2;
    logic en_s3;
  } pipe_ctrl_t;

endpackage

FILE: hw/rtl/dsr_lane.sv
// one output coordinate: three products, rounded sum and saturation
module dsr_lane
  import dsr_pkg::*;
(
  input  logic                      clk_i,
  input  pipe_ctrl_t                ctrl_i,
  input  logic [COEFS_W-1:0]        coefs_i,
  input  logic signed [COORD_W-1:0] x_i,
  input  logic signed [COORD_W-1:0] y_i,
  input  logic signed [COORD_W-1:0] z_i,
  output logic signed [COORD_W-1:0] res_o
);

  logic signed [COEF_W-1:0]  coef_x, coef_y, coef_z;
  logic signed [PROD_W-1:0]  prod_x_d, prod_y_d, prod_z_d;
  logic signed [PROD_W-1:0]  prod_x_q, prod_y_q, prod_z_q;
  logic signed [SUM_W-1:0]   sum_d, sum_q;
  logic signed [SUM_W-1:0]   scaled;

  // unpack the three weights
  assign coef_x = signed'(coefs_i[0 +: COEF_W]);
  assign coef_y = signed'(coefs_i[COEF_W +: COEF_W]);
  assign coef_z = signed'(coefs_i[2 * COEF_W +: COEF_W]);

  // stage 2: products
  assign prod_x_d = PROD_W'(x_i) * PROD_W'(coef_x);
  assign prod_y_d = PROD_W'(y_i) * PROD_W'(coef_y);
  assign prod_z_d = PROD_W'(z_i) * PROD_W'(coef_z);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_s2) begin
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
      prod_z_q <= prod_z_d;
    end
  end

  // stage 3: exact sum plus rounding bias
  assign sum_d = SUM_W'(prod_x_q) + SUM_W'(prod_y_q) + SUM_W'(prod_z_q) + ROUND_BIAS;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_s3) begin
      sum_q <= sum_d;
    end
  end

  // drop the fraction (floor) and clamp to the coordinate range
  assign scaled = sum_q >>> COEF_FRAC;

  always_comb begin
    if (scaled > SAT_MAX) begin
      res_o = SAT_MAX[COORD_W-1:0];
    end else if (scaled < SAT_MIN) begin
      res_o = SAT_MIN[COORD_W-1:0];
    end else begin
      res_o = scaled[COORD_W-1:0];
    end
  end

endmodule

FILE: hw/rtl/dihedral_subset_rotation_top.sv
// dihedral subset rotation: selects atoms on the moving side and rotates them
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o  | atom_node, is_oxygen, x/y/z_in, last_atom
//   out     | output    | out_valid_o / out_stall_i| x/y/z_out, was_rotated, last_out
//   cfg     | input     | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// one atom per cycle while out_stall_i is low; atoms pass s1, s2, s3 and output register
// stages: input and side select, 24x18 products, three-term sum with rounding, saturate
// each stage loads when empty or when the stage after it moves, so bubbles fill under stall
// rst_ni clears the stage valid bits and loads the identity matrix, pivot 0 and phi mode
`include "dihedral_subset_rotation_top_defines.svh"

module dihedral_subset_rotation_top
  import dsr_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration writes
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  // atom input
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [NODE_BITS-1:0]      atom_node_i,
  input  logic                      is_oxygen_i,
  input  logic signed [COORD_W-1:0] x_in_i,
  input  logic signed [COORD_W-1:0] y_in_i,
  input  logic signed [COORD_W-1:0] z_in_i,
  input  logic                      last_atom_i,
  // result output
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [COORD_W-1:0] x_out_o,
  output logic signed [COORD_W-1:0] y_out_o,
  output logic signed [COORD_W-1:0] z_out_o,
  output logic                      was_rotated_o,
  output logic                      last_out_o
);

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      sel;
    logic                      last;
  } side_t;

  logic [COEFS_W-1:0]   x_coefs_q, y_coefs_q, z_coefs_q;
  logic [NODE_BITS-1:0] pivot_q;
  logic                 side_mode_q;

  logic       s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic       en_s1, en_s2, en_s3, en_out;
  pipe_ctrl_t ctrl;
  logic       sel_d;
  side_t      s1_d, s1_q, s2_q, s3_q;

  logic signed [COORD_W-1:0] rot_x, rot_y, rot_z;
  logic signed [COORD_W-1:0] x_out_q, y_out_q, z_out_q;
  logic                      rot_q, last_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_coefs_q   <= X_COEFS_RST;
      y_coefs_q   <= Y_COEFS_RST;
      z_coefs_q   <= Z_COEFS_RST;
      pivot_q     <= '0;
      side_mode_q <= SIDE_PHI;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_X_COEFS:   x_coefs_q   <= cfg_data_i[COEFS_W-1:0];
        REG_Y_COEFS:   y_coefs_q   <= cfg_data_i[COEFS_W-1:0];
        REG_Z_COEFS:   z_coefs_q   <= cfg_data_i[COEFS_W-1:0];
        REG_PIVOT:     pivot_q     <= cfg_data_i[NODE_BITS-1:0];
        REG_SIDE_MODE: side_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // stage load enables, from the output back to the input
  assign en_out     = !out_valid_q || !out_stall_i;
  assign en_s3      = !s3_valid_q || en_out;
  assign en_s2      = !s2_valid_q || en_s3;
  assign en_s1      = !s1_valid_q || en_s2;
  assign in_stall_o = !en_s1;
  assign ctrl.en_s2 = en_s2;
  assign ctrl.en_s3 = en_s3;

  // moving side of the dihedral
  always_comb begin
    if (side_mode_q == SIDE_PSI) begin
      sel_d = atom_node_i < pivot_q;
    end else begin
      sel_d = (atom_node_i > pivot_q) || ((atom_node_i == pivot_q) && is_oxygen_i);
    end
  end

  assign s1_d.x    = x_in_i;
  assign s1_d.y    = y_in_i;
  assign s1_d.z    = z_in_i;
  assign s1_d.sel  = sel_d;
  assign s1_d.last = last_atom_i;

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en_s1)  s1_valid_q  <= in_valid_i;
      if (en_s2)  s2_valid_q  <= s1_valid_q;
      if (en_s3)  s3_valid_q  <= s2_valid_q;
      if (en_out) out_valid_q <= s3_valid_q;
    end
  end

  // pass-through payload alongside the arithmetic
  always_ff @(posedge clk_i) begin
    if (en_s1) s1_q <= s1_d;
    if (en_s2) s2_q <= s1_q;
    if (en_s3) s3_q <= s2_q;
  end

  // one lane per output coordinate
  dsr_lane u_lane_x (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .coefs_i (x_coefs_q),
    .x_i     (s1_q.x),
    .y_i     (s1_q.y),
    .z_i     (s1_q.z),
    .res_o   (rot_x)
  );

  dsr_lane u_lane_y (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .coefs_i (y_coefs_q),
    .x_i     (s1_q.x),
    .y_i     (s1_q.y),
    .z_i     (s1_q.z),
    .res_o   (rot_y)
  );

  dsr_lane u_lane_z (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .coefs_i (z_coefs_q),
    .x_i     (s1_q.x),
    .y_i     (s1_q.y),
    .z_i     (s1_q.z),
    .res_o   (rot_z)
  );

  // output register: rotated or original coordinates
  always_ff @(posedge clk_i) begin
    if (en_out) begin
      x_out_q <= s3_q.sel ? rot_x : s3_q.x;
      y_out_q <= s3_q.sel ? rot_y : s3_q.y;
      z_out_q <= s3_q.sel ? rot_z : s3_q.z;
      rot_q   <= s3_q.sel;
      last_q  <= s3_q.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign x_out_o       = x_out_q;
  assign y_out_o       = y_out_q;
  assign z_out_o       = z_out_q;
  assign was_rotated_o = rot_q;
  assign last_out_o    = last_q;

  // input stalls only when every stage holds a transaction
  `DSR_ASSERT(a_stall_full, in_stall_o, s1_valid_q && s2_valid_q && s3_valid_q && out_valid_q)
  // a held first stage keeps its transaction
  `DSR_ASSERT_NEXT(a_s1_hold, s1_valid_q && !en_s2, s1_valid_q)
  // a transaction leaving the last arithmetic stage lands in the output register
  `DSR_ASSERT_NEXT(a_s3_to_out, s3_valid_q && en_out, out_valid_q)
  // with a free output register no stage may be blocked
  `DSR_ASSERT(a_free_flow, !out_valid_q, en_s3 && en_s2 && en_s1)

endmodule
